### rtl/spa_pkg.sv
// Package: shared constants, payload structs and codes for the segment allocator.
`default_nettype none
package spa_pkg;
   localparam int MaxSegments = 64;
   localparam int AddrBits    = 16;
   localparam int IdxBits     = $clog2(MaxSegments);
   localparam int CntBits     = $clog2(MaxSegments + 1);
   localparam int LimBits     = AddrBits + 1;
   localparam int EndBits     = AddrBits + 2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] REG_FIT_MODE = 2'd0;
   localparam logic [1:0] REG_MEM_SIZE = 2'd1;

   typedef struct packed {
      logic                cmd;
      logic [AddrBits-1:0] seg_size;
      logic [AddrBits-1:0] seg_base;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [AddrBits-1:0] alloc_base;
      logic [6:0]          used_count;
   } rsp_type;
endpackage
`default_nettype wire

### rtl/segment_placement_allocator_top.sv
// Top level: segment table in two synchronous memories, scanned and shifted by a sequencer.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_start / req_busy | req_item (req_type)
//  rsp     | out       | rsp_strobe           | rsp_item (rsp_type)
//  csr     | in        | APB psel/penable     | fit_mode, memory_size
//
// An allocate scans the table to decide, then, if there is room, moves the entries above
// the new one up one at a time and writes it; a free scans for the base and, on a hit, moves
// the entries above it down one at a time; each command then shows its result.
// Each table memory has a single read port, so the scan reads one entry per cycle.
// Reset: synchronous, clears count, sequencer and fit mode, sets memory size to 65536; tables stay uninitialised.
// busy is high from the cycle after acceptance through the strobe cycle.
// The receiver cannot stall; the result is shown for one cycle.
`default_nettype none
module segment_placement_allocator_top
   import spa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   output logic             req_busy,
   input  wire req_type     req_item,
   output logic             rsp_strobe,
   output rsp_type          rsp_item,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_SWAIT = 7'b0000100,
      S_DEC   = 7'b0001000,
      S_SHIFT = 7'b0010000,
      S_SWR   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic                fit_ff;
   logic [LimBits-1:0]  msize_ff;
   logic [CntBits-1:0]  count_ff, count_in;
   req_type             req_ff;
   logic [CntBits-1:0]  ptr_ff, ptr_in;     // read pointer during scan/shift
   logic                rvld_ff;            // read data valid this cycle
   logic [CntBits-1:0]  ridx_ff;            // index of the data now on rd
   logic [EndBits-1:0]  prev_end_ff, prev_end_in;
   logic                have_ff, have_in;
   logic [EndBits-1:0]  best_gap_ff, best_gap_in;
   logic [EndBits-1:0]  best_base_ff, best_base_in;
   logic                stop_ff, stop_in;   // first fit found, or free hit
   logic [CntBits-1:0]  pos_ff, pos_in;     // free hit index
   logic                posv_ff, posv_in;
   logic [1:0]          status_ff, status_in;
   logic [AddrBits-1:0] base_ff, base_in;
   logic [AddrBits-1:0] nbase_ff, nbase_in; // entry to write
   logic [AddrBits-1:0] nsize_ff, nsize_in;
   logic [CntBits-1:0]  wpos_ff, wpos_in;   // next write slot during shift

   logic [AddrBits-1:0] base_mem [MaxSegments];
   logic [AddrBits-1:0] size_mem [MaxSegments];
   logic [AddrBits-1:0] rd_base, rd_size;
   logic                mem_we;
   logic [IdxBits-1:0]  mem_wa, mem_ra;
   logic [AddrBits-1:0] mem_wb, mem_ws;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         base_mem[mem_wa] <= mem_wb;
         size_mem[mem_wa] <= mem_ws;
      end
      rd_base <= base_mem[mem_ra];
      rd_size <= size_mem[mem_ra];
   end

   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_MEM_SIZE[0]) csr_prdata[LimBits-1:0] = msize_ff;
      else csr_prdata[0] = fit_ff;
   end

   logic accept;
   assign accept   = req_start && !req_busy;
   assign req_busy = (state_ff != S_IDLE);

   logic [EndBits-1:0] limit, rd_end, gap, sz_ext, tail;
   assign limit  = (msize_ff > LimBits'(1 << AddrBits)) ?
                   EndBits'(1 << AddrBits) : EndBits'(msize_ff);
   assign rd_end = EndBits'(rd_base) + EndBits'(rd_size);
   assign gap    = EndBits'(rd_base) - prev_end_ff;
   assign sz_ext = EndBits'(req_ff.seg_size);
   assign tail   = prev_end_ff;

   logic is_alloc;
   assign is_alloc = (req_ff.cmd == CMD_ALLOC);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      prev_end_in  = prev_end_ff;
      have_in      = have_ff;
      best_gap_in  = best_gap_ff;
      best_base_in = best_base_ff;
      stop_in      = stop_ff;
      pos_in       = pos_ff;
      posv_in      = posv_ff;
      status_in    = status_ff;
      base_in      = base_ff;
      nbase_in     = nbase_ff;
      nsize_in     = nsize_ff;
      wpos_in      = wpos_ff;
      mem_we       = 1'b0;
      mem_wa       = wpos_ff[IdxBits-1:0];
      mem_wb       = nbase_ff;
      mem_ws       = nsize_ff;
      mem_ra       = ptr_ff[IdxBits-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               ptr_in   = '0;
               have_in  = 1'b0;
               stop_in  = 1'b0;
               posv_in  = 1'b0;
               status_in = ST_OK;
               base_in  = '0;
            end
         end
         S_SCAN: begin
            // issue reads 0..count-1, unless stopped
            if (rvld_ff) begin
               if (is_alloc) begin
                  if (ridx_ff != '0 && EndBits'(rd_base) > prev_end_ff &&
                      gap >= sz_ext && !stop_ff) begin
                     if (!have_ff || gap < best_gap_ff) begin
                        have_in      = 1'b1;
                        best_gap_in  = gap;
                        best_base_in = prev_end_ff;
                     end
                     if (!fit_ff) stop_in = 1'b1;
                  end
                  prev_end_in = rd_end;
               end else if (!stop_ff && rd_base == req_ff.seg_base) begin
                  stop_in = 1'b1;
                  pos_in  = ridx_ff;
               end
            end
            if (ptr_ff < count_ff && !stop_in) ptr_in = ptr_ff + 1'b1;
            else state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (!rvld_ff) state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_DONE;
            if (is_alloc) begin
               if (count_ff >= CntBits'(MaxSegments)) status_in = ST_FULL;
               else if (req_ff.seg_size == '0) status_in = ST_NO_SPACE;
               else if (count_ff == '0) begin
                  if (sz_ext <= limit) begin
                     nbase_in = '0; nsize_in = req_ff.seg_size;
                     mem_we = 1'b1; mem_wa = '0;
                     mem_wb = '0; mem_ws = req_ff.seg_size;
                     count_in = count_ff + 1'b1;
                  end else status_in = ST_NO_SPACE;
               end else begin
                  if (have_ff && best_base_ff + sz_ext <= limit)
                     base_in = best_base_ff[AddrBits-1:0];
                  else if (tail + sz_ext <= limit)
                     base_in = tail[AddrBits-1:0];
                  else status_in = ST_NO_SPACE;
                  if (!(have_ff && best_base_ff + sz_ext <= limit) &&
                      !(tail + sz_ext <= limit)) begin
                     state_in = S_DONE;
                  end else begin
                     // shift entries from the top down to make room
                     state_in = S_SHIFT;
                     nbase_in = '0;
                     nsize_in = req_ff.seg_size;
                     ptr_in   = count_ff - 1'b1;
                     wpos_in  = count_ff;
                  end
               end
            end else begin
               if (!stop_ff) status_in = ST_NOT_FOUND;
               else begin
                  state_in = S_SHIFT;
                  ptr_in   = pos_ff + 1'b1;
                  wpos_in  = pos_ff;
               end
            end
         end
         S_SHIFT: begin
            state_in = S_SWR;
         end
         S_SWR: begin
            // rd holds entry read from ptr
            if (is_alloc) begin
               if (!posv_ff && rd_base > base_ff) begin
                  mem_we = 1'b1; mem_wa = wpos_ff[IdxBits-1:0];
                  mem_wb = rd_base; mem_ws = rd_size;
                  wpos_in = wpos_ff - 1'b1;
                  if (ptr_ff == '0) begin
                     posv_in = 1'b1;
                     state_in = S_SWR;
                  end else begin
                     ptr_in = ptr_ff - 1'b1;
                     state_in = S_SHIFT;
                  end
               end else begin
                  mem_we = 1'b1; mem_wa = wpos_ff[IdxBits-1:0];
                  mem_wb = base_ff; mem_ws = req_ff.seg_size;
                  count_in = count_ff + 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               if (ptr_ff >= count_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_DONE;
               end else begin
                  mem_we = 1'b1; mem_wa = wpos_ff[IdxBits-1:0];
                  mem_wb = rd_base; mem_ws = rd_size;
                  wpos_in = wpos_ff + 1'b1;
                  ptr_in = ptr_ff + 1'b1;
                  state_in = S_SHIFT;
               end
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         fit_ff   <= 1'b0;
         msize_ff <= LimBits'(65536);
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rvld_ff  <= (state_ff == S_SCAN) && (ptr_ff < count_ff) && !stop_in;
         if (csr_wr && csr_paddr[2:1] == '0) begin
            if (csr_paddr[2] == REG_FIT_MODE[0]) fit_ff <= csr_pwdata[0];
         end
         if (csr_wr && csr_paddr[2] == REG_MEM_SIZE[0])
            msize_ff <= csr_pwdata[LimBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_item;
      ridx_ff      <= ptr_ff;
      ptr_ff       <= ptr_in;
      prev_end_ff  <= (state_ff == S_IDLE) ? '0 : prev_end_in;
      have_ff      <= have_in;
      best_gap_ff  <= best_gap_in;
      best_base_ff <= best_base_in;
      stop_ff      <= stop_in;
      pos_ff       <= pos_in;
      posv_ff      <= posv_in;
      status_ff    <= status_in;
      base_ff      <= base_in;
      nbase_ff     <= nbase_in;
      nsize_ff     <= nsize_in;
      wpos_ff      <= wpos_in;
   end

   assign rsp_strobe          = (state_ff == S_DONE);
   assign rsp_item.status     = status_ff;
   assign rsp_item.alloc_base = (status_ff == ST_OK && is_alloc) ? base_ff : '0;
   assign rsp_item.used_count = 7'(count_ff);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(MaxSegments)) else $error("count overflow");
   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> req_busy) else $error("strobe while idle");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> rsp_strobe)
      else $error("count changed outside item");
endmodule
`default_nettype wire

### tb/sv/spa_checker.sv
// Checker: watches the request and result channels, predicts and compares each item.
`timescale 1ns / 1ps
module spa_checker
   import spa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   input  wire logic        req_busy,
   input  wire req_type     req_item,
   input  wire logic        rsp_strobe,
   input  wire rsp_type     rsp_item,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output int               fail_count,
   output int               pending
);
   logic [16:0] tbl_base [0:MaxSegments];
   logic [16:0] tbl_size [0:MaxSegments];
   int          held;
   logic        best_fit;
   logic [16:0] mem_bytes;
   rsp_type     awaited_rsp [$];

   assign pending = awaited_rsp.size();

   function automatic rsp_type place_or_free(req_type r);
      rsp_type     o;
      logic [17:0] lim, tail, gap, prev_end, pick_gap, pick_base;
      bit          have, ok;
      int          i, pos;
      o = '0;
      o.status = ST_OK;
      lim = (mem_bytes > 17'h10000) ? 18'h10000 : {1'b0, mem_bytes};
      if (r.cmd == CMD_ALLOC) begin
         if (held >= MaxSegments) begin
            o.status = ST_FULL;
         end else if (r.seg_size == 0) begin
            o.status = ST_NO_SPACE;
         end else begin
            ok = 0;
            pick_base = 0;
            if (held == 0) begin
               ok = (r.seg_size <= lim);
            end else begin
               have = 0;
               pick_gap = 0;
               for (i = 1; i < held; i++) begin
                  prev_end = tbl_base[i-1] + tbl_size[i-1];
                  if (tbl_base[i] <= prev_end) continue;
                  gap = tbl_base[i] - prev_end;
                  if (gap < r.seg_size) continue;
                  if (!have || gap < pick_gap) begin
                     have = 1;
                     pick_gap = gap;
                     pick_base = prev_end;
                  end
                  if (!best_fit) break;
               end
               if (have && pick_base + r.seg_size <= lim) begin
                  ok = 1;
               end else begin
                  tail = tbl_base[held-1] + tbl_size[held-1];
                  if (tail + r.seg_size <= lim) begin
                     ok = 1;
                     pick_base = tail;
                  end
               end
            end
            if (!ok) begin
               o.status = ST_NO_SPACE;
            end else begin
               pos = 0;
               while (pos < held && tbl_base[pos] < pick_base) pos++;
               for (i = held; i > pos; i--) begin
                  tbl_base[i] = tbl_base[i-1];
                  tbl_size[i] = tbl_size[i-1];
               end
               tbl_base[pos] = {1'b0, pick_base[15:0]};
               tbl_size[pos] = {1'b0, r.seg_size};
               held++;
               o.alloc_base = pick_base[15:0];
            end
         end
      end else begin
         pos = held;
         for (i = 0; i < held; i++)
            if (tbl_base[i] == r.seg_base) begin
               pos = i;
               break;
            end
         if (pos == held) begin
            o.status = ST_NOT_FOUND;
         end else begin
            for (i = pos; i + 1 < held; i++) begin
               tbl_base[i] = tbl_base[i+1];
               tbl_size[i] = tbl_size[i+1];
            end
            held--;
         end
      end
      o.used_count = held[6:0];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         held = 0;
         best_fit <= 0;
         mem_bytes <= 17'h10000;
         awaited_rsp.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == REG_FIT_MODE[0]) best_fit <= csr_pwdata[0];
            else mem_bytes <= csr_pwdata[16:0];
         end
         if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               $error("result with no item outstanding");
               errs++;
            end else begin
               want = awaited_rsp.pop_front();
               if (want.status !== rsp_item.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_item.status);
                  errs++;
               end
               if (want.alloc_base !== rsp_item.alloc_base) begin
                  $error("alloc_base expected %0d got %0d", want.alloc_base,
                         rsp_item.alloc_base);
                  errs++;
               end
               if (want.used_count !== rsp_item.used_count) begin
                  $error("used_count expected %0d got %0d", want.used_count,
                         rsp_item.used_count);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         // blocking update of the table so a following item sees it at once
         if (req_start && !req_busy) awaited_rsp.push_back(place_or_free(req_item));
      end
   end
endmodule

### tb/sv/testbench.sv
// Testbench top: clock, reset, register writes, request stimulus and the verdict.
`timescale 1ns / 1ps
module testbench;
   import spa_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_start = 0;
   logic        req_busy;
   req_type     req_item = '0;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending;
   int          idle_pct;
   int          quiet_cycles;
   logic [15:0] live_bases [$];

   localparam int QuietLimit = 20000;

   always #6 clock = ~clock;

   segment_placement_allocator_top dut (.*);
   spa_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (req_start && !req_busy) || rsp_strobe || csr_psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // live bases tracked from results so frees mostly hit
   always @(posedge clock)
      if (!reset && rsp_strobe && rsp_item.status == ST_OK && rsp_item.alloc_base != 0
          || !reset && rsp_strobe && rsp_item.status == ST_OK && rsp_item.used_count == 1
             && live_bases.size() == 0)
         live_bases.push_back(rsp_item.alloc_base);

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= 3'({idx, 2'b00}); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   // returns just after the accepting edge; start is dropped by the next idle or drain
   task automatic send(input logic cmd, input logic [15:0] sz, input logic [15:0] bs);
      while ($urandom_range(99) < idle_pct) begin
         req_start <= 0;
         @(posedge clock);
      end
      req_start <= 1;
      req_item <= '{cmd: cmd, seg_size: sz, seg_base: bs};
      @(negedge clock);
      while (req_busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain();
      req_start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_items(input int n);
      int          k, idx;
      logic [15:0] sz, bs;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0: sz = 16'($urandom);
            1: sz = 16'(16'hFFFF - $urandom_range(3));
            default: sz = 16'($urandom_range(1, 3000));
         endcase
         if ($urandom_range(1) == 0 && live_bases.size() < 70) begin
            send(CMD_ALLOC, sz, 16'($urandom));
         end else if (live_bases.size() != 0 && $urandom_range(7) != 0) begin
            idx = $urandom_range(live_bases.size() - 1);
            bs = live_bases[idx];
            live_bases.delete(idx);
            send(CMD_FREE, 16'($urandom), bs);
         end else begin
            send(CMD_FREE, 16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      int k;
      idle_pct = 38;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty table, zero size, whole memory, table full, free miss
      send(CMD_ALLOC, 16'd0, 16'hFFFF);
      send(CMD_FREE, 16'hFFFF, 16'd0);
      send(CMD_ALLOC, 16'hFFFF, 16'd0);
      send(CMD_ALLOC, 16'd1, 16'd0);
      send(CMD_ALLOC, 16'd1, 16'd0);
      send(CMD_FREE, 16'd0, 16'd0);
      send(CMD_FREE, 16'd0, 16'hFFFF);
      send(CMD_FREE, 16'd0, 16'd0);
      for (k = 0; k < 66; k++) send(CMD_ALLOC, 16'd8, 16'd0);
      for (k = 0; k < 64; k++) send(CMD_FREE, 16'd0, 16'(8 * k));
      live_bases.delete();
      drain();
      csr_write(REG_MEM_SIZE, 32'd0);
      send(CMD_ALLOC, 16'd1, 16'd0);
      drain();
      csr_write(REG_MEM_SIZE, 32'h1FFFF);
      csr_write(REG_FIT_MODE, 32'd1);
      random_items(280);
      drain();
      idle_pct = 79;
      csr_write(REG_FIT_MODE, 32'd0);
      csr_write(REG_MEM_SIZE, 32'd20000);
      random_items(280);
      drain();
      idle_pct = 0;
      csr_write(REG_FIT_MODE, 32'hFFFFFFFF);
      csr_write(REG_MEM_SIZE, 32'd1);
      random_items(20);
      drain();
      csr_write(REG_MEM_SIZE, 32'h10000);
      random_items(280);
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
